// ===== rtl/core/nfpa_pkg.sv =====
// Shared constants and types for the next-fit page allocator.
// No dependencies.
package nfpa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 256;
  localparam int unsigned PAGE_BITS_DEF  = 12;

  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  localparam logic [31:0] HEAP_BASE_RST = 32'h8000_0000;
  localparam logic [31:0] HEAP_SIZE_RST = 32'h2000_0000;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
    logic        used;
  } blk_t;

endpackage

// ===== rtl/core/nfpa_if.sv =====
// Request and response channel interfaces of the page allocator.
// Depends on nfpa_pkg.
interface nfpa_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] req_size;
  logic [31:0] address;
  modport source (output valid, func, req_size, address, input ready);
  modport sink   (input valid, func, req_size, address, output ready);
endinterface

interface nfpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [31:0]                   result_address;
  logic [31:0]                   granted_size;
  logic [nfpa_pkg::STATUS_W-1:0] status;
  modport source (output valid, result_address, granted_size, status, input ready);
  modport sink   (input valid, result_address, granted_size, status, output ready);
endinterface

// ===== rtl/core/nfpa_engine.sv =====
// Block table memory and the sequencer that scans it for alloc and free.
// Depends on nfpa_pkg and nfpa_if.
module nfpa_engine #(
  parameter int unsigned MAX_BLOCKS = nfpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned PAGE_BITS  = nfpa_pkg::PAGE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] heap_base_i,
  input  logic [31:0] heap_size_i,
  nfpa_req_if.sink    req_i,
  nfpa_rsp_if.source  rsp_o
);
  import nfpa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);
  localparam logic [32:0] PMASK = (33'd1 << PAGE_BITS) - 33'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_ARD, S_ACHK, S_SRD, S_SCHK, S_AWR,
    S_FRD, S_FCHK, S_MRD, S_MCHK, S_MWB, S_DONE
  } state_e;

  state_e state_q;
  logic [IW-1:0] idx_q, cnt_q, hit_q, fp_q, cur_idx_q;
  logic          ready_q;
  logic [31:0]   req_q, va_q, rest_q, cur_base_q, cur_len_q, rel_len_q;
  logic [32:0]   need_q;
  logic [31:0]   res_addr_q, res_size_q;
  logic [STATUS_W-1:0] res_st_q;
  logic          out_valid_q;
  logic [31:0]   out_addr_q, out_size_q;
  logic [STATUS_W-1:0] out_st_q;

  blk_t mem [MAX_BLOCKS];
  blk_t rdata_q, wdata;
  logic we;
  logic [IW-1:0] waddr;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[idx_q];
  end

  logic        elig, empty, merge_up, merge_dn, cand;
  logic [31:0] rest;
  logic [IW-1:0] idx_nx;
  logic [32:0] need_in;
  logic        rsp_load;

  assign need_in = ({1'b0, req_i.req_size} + PMASK) & ~PMASK;
  assign idx_nx  = (idx_q == LAST) ? '0 : idx_q + 1'b1;
  assign elig  = !rdata_q.used && ({1'b0, rdata_q.len} >= need_q) &&
                 (rdata_q.base >= heap_base_i);
  assign rest  = rdata_q.len - need_q[31:0];
  assign empty = (rdata_q.base == '0) && (rdata_q.len == '0) && !rdata_q.used;
  assign cand  = (idx_q != cur_idx_q) && !rdata_q.used && (rdata_q.len != '0);
  assign merge_up = cand && (cur_base_q + cur_len_q == rdata_q.base);
  assign merge_dn = cand && !merge_up && (rdata_q.base + rdata_q.len == cur_base_q);
  assign rsp_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        if (idx_q == '0) wdata = '{base: heap_base_i, len: heap_size_i, used: 1'b0};
      end
      S_ACHK: begin
        if (elig && rest == '0) begin
          we    = 1'b1;
          wdata = '{base: rdata_q.base, len: rdata_q.len, used: 1'b1};
        end
      end
      S_SCHK: begin
        if (empty) begin
          we    = 1'b1;
          wdata = '{base: va_q + need_q[31:0], len: rest_q, used: 1'b0};
        end
      end
      S_AWR: begin
        we    = 1'b1;
        waddr = hit_q;
        wdata = '{base: va_q, len: need_q[31:0], used: 1'b1};
      end
      S_MCHK: begin
        if (merge_up) we = 1'b1;
        else if (merge_dn) begin
          we    = 1'b1;
          waddr = cur_idx_q;
        end
      end
      S_MWB: begin
        we    = 1'b1;
        waddr = cur_idx_q;
        wdata = '{base: cur_base_q, len: cur_len_q, used: 1'b0};
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.result_address = out_addr_q;
  assign rsp_o.granted_size   = out_size_q;
  assign rsp_o.status         = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      fp_q        <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rsp_load) out_valid_q <= 1'b1;
      else if (out_valid_q && rsp_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q  <= req_i.req_size;
            need_q <= need_in;
            va_q   <= req_i.address & ~PMASK[31:0];
            res_addr_q <= '0;
            res_size_q <= '0;
            idx_q  <= '0;
            cnt_q  <= '0;
            if (req_i.func == FUNC_ALLOC) begin
              if (req_i.req_size == '0) begin
                res_st_q <= ST_NULL;
                state_q  <= S_DONE;
              end else if (!ready_q) begin
                state_q <= S_CLEAR;
              end else if (req_i.req_size > heap_size_i) begin
                res_st_q <= ST_NOFIT;
                state_q  <= S_DONE;
              end else begin
                idx_q   <= fp_q;
                state_q <= S_ARD;
              end
            end else begin
              if (req_i.address == '0) begin
                res_st_q <= ST_NULL;
                state_q  <= S_DONE;
              end else if (!ready_q) begin
                // table not built yet: nothing is in use
                res_st_q <= ST_NOTFOUND;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_FRD;
              end
            end
          end
        end
        S_CLEAR: begin
          idx_q <= idx_nx;
          if (idx_q == LAST) begin
            ready_q <= 1'b1;
            if (req_q > heap_size_i) begin
              res_st_q <= ST_NOFIT;
              state_q  <= S_DONE;
            end else begin
              idx_q   <= fp_q;
              state_q <= S_ARD;
            end
          end
        end
        S_ARD: state_q <= S_ACHK;
        S_ACHK: begin
          if (elig) begin
            if (rest == '0) begin
              fp_q       <= idx_nx;
              res_addr_q <= rdata_q.base;
              res_size_q <= need_q[31:0];
              res_st_q   <= ST_OK;
              state_q    <= S_DONE;
            end else begin
              hit_q   <= idx_q;
              va_q    <= rdata_q.base;
              rest_q  <= rest;
              idx_q   <= '0;
              state_q <= S_SRD;
            end
          end else if (cnt_q == LAST) begin
            res_st_q <= ST_NOFIT;
            state_q  <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            idx_q   <= idx_nx;
            state_q <= S_ARD;
          end
        end
        S_SRD: state_q <= S_SCHK;
        S_SCHK: begin
          if (empty) begin
            state_q <= S_AWR;
          end else if (idx_q == LAST) begin
            res_st_q <= ST_NOSLOT;
            state_q  <= S_DONE;
          end else begin
            idx_q   <= idx_nx;
            state_q <= S_SRD;
          end
        end
        S_AWR: begin
          fp_q       <= (hit_q == LAST) ? '0 : hit_q + 1'b1;
          res_addr_q <= va_q;
          res_size_q <= need_q[31:0];
          res_st_q   <= ST_OK;
          state_q    <= S_DONE;
        end
        S_FRD: state_q <= S_FCHK;
        S_FCHK: begin
          if (rdata_q.used && rdata_q.base == va_q) begin
            cur_idx_q  <= idx_q;
            cur_base_q <= rdata_q.base;
            cur_len_q  <= rdata_q.len;
            rel_len_q  <= rdata_q.len;
            idx_q      <= '0;
            state_q    <= S_MRD;
          end else if (idx_q == LAST) begin
            res_st_q <= ST_NOTFOUND;
            state_q  <= S_DONE;
          end else begin
            idx_q   <= idx_nx;
            state_q <= S_FRD;
          end
        end
        S_MRD: state_q <= S_MCHK;
        S_MCHK: begin
          if (merge_up) begin
            cur_len_q <= cur_len_q + rdata_q.len;
          end else if (merge_dn) begin
            cur_idx_q  <= idx_q;
            cur_base_q <= rdata_q.base;
            cur_len_q  <= rdata_q.len + cur_len_q;
          end
          idx_q   <= idx_nx;
          state_q <= (idx_q == LAST) ? S_MWB : S_MRD;
        end
        S_MWB: begin
          res_size_q <= rel_len_q;
          res_st_q   <= ST_OK;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            out_addr_q  <= res_addr_q;
            out_size_q  <= res_size_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !we)
    else $error("table write outside an operation");
  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ready_q))
    else $error("table setup flag dropped");
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside completion");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fp_q <= LAST) && (idx_q <= LAST))
    else $error("table index out of range");

endmodule

// ===== rtl/core/next_fit_page_allocator_unit.sv =====
// Top level of the next-fit page allocator: APB registers and the table engine.
// Depends on nfpa_pkg, nfpa_if and nfpa_engine.
//
//  channel | dir | handshake     | payload
//  req_i   | in  | valid/ready   | func, req_size, address
//  rsp_o   | out | valid/ready   | result_address, granted_size, status
//  apb     | in  | psel/penable  | paddr, pwdata, prdata (heap_base, heap_size)
//
// One item at a time; each table entry visit takes a read state and a check state on the
// single table read port. Alloc: a search of up to MAX_BLOCKS entries plus a slot scan.
// Free: a lookup of up to MAX_BLOCKS entries plus a merge pass over the whole table.
// The first nonzero alloc after reset first clears the table.
// The table has no reset; the result is held in an output register until taken.
module next_fit_page_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = nfpa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned PAGE_BITS  = nfpa_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nfpa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  nfpa_req_if.sink                     req_i,
  nfpa_rsp_if.source                   rsp_o
);
  import nfpa_pkg::*;

  logic [31:0] heap_base_q, heap_size_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_SIZE) ? heap_size_q : heap_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HEAP_BASE_RST;
      heap_size_q <= HEAP_SIZE_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HEAP_BASE) heap_base_q <= pwdata;
      else heap_size_q <= pwdata;
    end
  end

  nfpa_engine #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .PAGE_BITS (PAGE_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .heap_base_i(heap_base_q),
    .heap_size_i(heap_size_q),
    .req_i      (req_i),
    .rsp_o      (rsp_o)
  );

endmodule

// ===== dv/next_fit_page_allocator_unit_tb.sv =====
// Self-checking testbench for next_fit_page_allocator_unit: allocate/free items with a
// predictor of the block table, APB heap setup and random stalls on both channels.
// Depends on nfpa_pkg, nfpa_if and the allocator RTL.
module next_fit_page_allocator_unit_tb;
  import nfpa_pkg::*;

  localparam int unsigned NBLK      = MAX_BLOCKS_DEF;
  localparam int unsigned CYCLE_CAP = 4_000_000;

  typedef struct packed {
    logic [31:0]         addr;
    logic [31:0]         size;
    logic [STATUS_W-1:0] status;
  } grant_t;

  typedef struct {
    logic        func;
    logic [31:0] req_size;
    logic [31:0] address;
    bit          typed;
    grant_t      want;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nfpa_req_if req_ch ();
  nfpa_rsp_if rsp_ch ();

  next_fit_page_allocator_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the allocator state
  logic [31:0] blk_base [NBLK];
  logic [31:0] blk_len  [NBLK];
  bit          blk_used [NBLK];
  logic [7:0]  next_fit;
  bit          table_built;
  logic [31:0] cfg_heap_base = HEAP_BASE_RST;
  logic [31:0] cfg_heap_size = HEAP_SIZE_RST;

  grant_t      pending_grants[$];
  logic [31:0] live_bases[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          status_hits[5];
  int          settings_used = 0;
  longint      cycles = 0;
  bit          src_burst = 1'b0;
  bit          snk_burst = 1'b0;

  function automatic grant_t predict_alloc(input logic [31:0] req);
    grant_t      g;
    logic [32:0] need;
    logic [31:0] sz, va, rest;
    logic [7:0]  i;
    int          j;
    g = '0;
    if (req == 32'd0) begin
      g.status = ST_NULL;
      return g;
    end
    need = ({1'b0, req} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;
    if (!table_built) begin
      for (int k = 0; k < NBLK; k++) begin
        blk_base[k] = '0;
        blk_len[k]  = '0;
        blk_used[k] = 1'b0;
      end
      blk_base[0] = cfg_heap_base;
      blk_len[0]  = cfg_heap_size;
      table_built = 1'b1;
    end
    if (req > cfg_heap_size) begin
      g.status = ST_NOFIT;
      return g;
    end
    for (int n = 0; n < NBLK; n++) begin
      i = next_fit + n[7:0];
      if (!blk_used[i] && {1'b0, blk_len[i]} >= need && blk_base[i] >= cfg_heap_base) begin
        sz   = need[31:0];
        va   = blk_base[i];
        rest = blk_len[i] - sz;
        if (rest != 32'd0) begin
          j = -1;
          for (int k = 0; k < NBLK; k++)
            if (j < 0 && blk_base[k] == '0 && blk_len[k] == '0 && !blk_used[k]) j = k;
          if (j < 0) begin
            g.status = ST_NOSLOT;
            return g;
          end
          blk_base[j] = va + sz;
          blk_len[j]  = rest;
          blk_used[j] = 1'b0;
          blk_len[i]  = sz;
        end
        blk_used[i] = 1'b1;
        next_fit    = i + 8'd1;
        g.addr   = va;
        g.size   = sz;
        g.status = ST_OK;
        return g;
      end
    end
    g.status = ST_NOFIT;
    return g;
  endfunction

  function automatic grant_t predict_free(input logic [31:0] addr);
    grant_t      g;
    logic [31:0] va;
    int          cur;
    g = '0;
    if (addr == 32'd0) begin
      g.status = ST_NULL;
      return g;
    end
    va  = addr & ~32'h0000_0FFF;
    cur = -1;
    for (int k = 0; k < NBLK; k++)
      if (cur < 0 && blk_used[k] && blk_base[k] == va) cur = k;
    if (cur < 0) begin
      g.status = ST_NOTFOUND;
      return g;
    end
    g.size        = blk_len[cur];
    g.status      = ST_OK;
    blk_used[cur] = 1'b0;
    // single merge pass in table order; cur follows the absorbing block
    for (int k = 0; k < NBLK; k++) begin
      if (k == cur || blk_used[k] || blk_len[k] == '0) continue;
      if (blk_base[cur] + blk_len[cur] == blk_base[k]) begin
        blk_len[cur] += blk_len[k];
        blk_base[k] = '0;
        blk_len[k]  = '0;
        blk_used[k] = 1'b0;
      end else if (blk_base[k] + blk_len[k] == blk_base[cur]) begin
        blk_len[k] += blk_len[cur];
        blk_base[cur] = '0;
        blk_len[cur]  = '0;
        blk_used[cur] = 1'b0;
        cur = k;
      end
    end
    return g;
  endfunction

  function automatic grant_t predict_request(input logic func, input logic [31:0] req,
                                             input logic [31:0] addr);
    grant_t g;
    if (func == FUNC_ALLOC) begin
      g = predict_alloc(req);
      if (g.status == ST_OK) live_bases.push_back(g.addr);
    end else begin
      g = predict_free(addr);
      if (g.status == ST_OK)
        for (int k = live_bases.size() - 1; k >= 0; k--)
          if (live_bases[k] == (addr & ~32'h0000_0FFF)) live_bases.delete(k);
    end
    return g;
  endfunction

  task automatic wait_drained();
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HEAP_BASE) cfg_heap_base = value;
    else cfg_heap_size = value;
  endtask

  task automatic send_request(input req_row_t row);
    int     gap;
    grant_t g;
    if ($urandom_range(0, 39) == 0) src_burst = ~src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= row.func;
    req_ch.req_size <= row.req_size;
    req_ch.address  <= row.address;
    do @(posedge clk_i); while (!req_ch.ready);
    // item taken: drop valid so it cannot be taken twice
    req_ch.valid <= 1'b0;
    g = predict_request(row.func, row.req_size, row.address);
    pending_grants.push_back(row.typed ? row.want : g);
    items_sent++;
  endtask

  // random item: mostly well-formed alloc/free traffic, some noise
  task automatic send_random(input int alloc_pct);
    req_row_t row;
    int       pick;
    row.typed = 1'b0;
    row.want  = '0;
    row.req_size = $urandom();
    row.address  = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0: row.func = FUNC_ALLOC;
        1: row.func = FUNC_FREE;
        2: begin row.func = FUNC_ALLOC; row.req_size = '0; end
        default: begin row.func = FUNC_FREE; row.address = '0; end
      endcase
    end else if (pick < 10 + alloc_pct || live_bases.size() == 0) begin
      row.func = FUNC_ALLOC;
      case ($urandom_range(0, 3))
        0: row.req_size = $urandom_range(1, 3) << 12;
        1: row.req_size = $urandom_range(1, 32'h3000);
        2: row.req_size = $urandom_range(1, 32'h40000);
        default: row.req_size = $urandom_range(1, 32'h1000);
      endcase
    end else begin
      row.func    = FUNC_FREE;
      row.address = live_bases[$urandom_range(0, live_bases.size() - 1)]
                    | $urandom_range(0, 32'hFFF);
    end
    send_request(row);
  endtask

  // response side
  initial begin
    int     stall;
    grant_t exp_g;
    rsp_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) snk_burst = ~snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid && rsp_ch.ready) || !rst_ni);
      results_seen++;
      if (pending_grants.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: addr=%h size=%h status=%0d", $time,
                 rsp_ch.result_address, rsp_ch.granted_size, rsp_ch.status);
      end else begin
        exp_g = pending_grants.pop_front();
        if (exp_g.status <= ST_NOTFOUND) status_hits[exp_g.status]++;
        if (rsp_ch.result_address !== exp_g.addr) begin
          errors++;
          $display("%0t: result_address expected %h actual %h", $time, exp_g.addr,
                   rsp_ch.result_address);
        end
        if (rsp_ch.granted_size !== exp_g.size) begin
          errors++;
          $display("%0t: granted_size expected %h actual %h", $time, exp_g.size,
                   rsp_ch.granted_size);
        end
        if (rsp_ch.status !== exp_g.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_g.status,
                   rsp_ch.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_grants.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_row_t mk_row(input logic func, input logic [31:0] req,
                                      input logic [31:0] addr, input bit typed,
                                      input logic [31:0] w_addr, input logic [31:0] w_size,
                                      input logic [STATUS_W-1:0] w_status);
    req_row_t r;
    r.func = func; r.req_size = req; r.address = addr; r.typed = typed;
    r.want = '{addr: w_addr, size: w_size, status: w_status};
    return r;
  endfunction

  initial begin
    req_row_t directed[$];
    req_ch.valid    = 1'b0;
    req_ch.func     = FUNC_ALLOC;
    req_ch.req_size = '0;
    req_ch.address  = '0;
    for (int k = 0; k < NBLK; k++) begin
      blk_base[k] = '0; blk_len[k] = '0; blk_used[k] = 1'b0;
    end
    next_fit    = '0;
    table_built = 1'b0;
    foreach (status_hits[k]) status_hits[k] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // small heap so that the table can run out of slots
    write_reg(REG_HEAP_BASE, 32'h0000_1000);
    write_reg(REG_HEAP_SIZE, 32'h0040_0000);
    settings_used++;

    directed.push_back(mk_row(FUNC_FREE,  0, 32'h1000, 1, 0, 0, ST_NOTFOUND));
    directed.push_back(mk_row(FUNC_FREE,  0, 0, 1, 0, 0, ST_NULL));
    directed.push_back(mk_row(FUNC_ALLOC, 0, 0, 1, 0, 0, ST_NULL));
    directed.push_back(mk_row(FUNC_ALLOC, 1, 0, 1, 32'h1000, 32'h1000, ST_OK));
    directed.push_back(mk_row(FUNC_ALLOC, 32'h1001, 0, 1, 32'h2000, 32'h2000, ST_OK));
    directed.push_back(mk_row(FUNC_ALLOC, 32'hFFFF_FFFF, 0, 1, 0, 0, ST_NOFIT));
    directed.push_back(mk_row(FUNC_ALLOC, 32'h8000_0000, 0, 1, 0, 0, ST_NOFIT));
    directed.push_back(mk_row(FUNC_ALLOC, 32'h40_0000, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_row(FUNC_FREE,  0, 32'h1FFF, 0, 0, 0, ST_OK));
    directed.push_back(mk_row(FUNC_FREE,  0, 32'h1000, 1, 0, 0, ST_NOTFOUND));
    directed.push_back(mk_row(FUNC_FREE,  0, 32'h2ABC, 0, 0, 0, ST_OK));
    directed.push_back(mk_row(FUNC_FREE,  0, 32'hFFFF_FFFF, 1, 0, 0, ST_NOTFOUND));
    directed.push_back(mk_row(FUNC_ALLOC, 32'h3F_F000, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_row(FUNC_ALLOC, 32'h40_0000, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_row(FUNC_FREE,  0, 32'h1000, 0, 0, 0, ST_OK));
    directed.push_back(mk_row(FUNC_ALLOC, 32'h40_0000, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_row(FUNC_FREE,  0, 32'h1000, 0, 0, 0, ST_OK));
    foreach (directed[k]) send_request(directed[k]);

    // alloc-heavy so the slot table fills up
    repeat (330) send_random(75);

    // zero heap size: every nonzero alloc is too big
    write_reg(REG_HEAP_SIZE, 32'h0000_0000);
    settings_used++;
    repeat (50) send_random(40);

    // top extremes: base check rejects every block, rounding overflows
    write_reg(REG_HEAP_BASE, 32'hFFFF_F000);
    write_reg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
    settings_used++;
    send_request(mk_row(FUNC_ALLOC, 32'hFFFF_FFFF, 0, 1, 0, 0, ST_NOFIT));
    repeat (60) send_random(40);

    // base in the middle: low blocks no longer eligible
    write_reg(REG_HEAP_BASE, 32'h0020_0000);
    write_reg(REG_HEAP_SIZE, 32'h0010_0000);
    settings_used++;
    repeat (120) send_random(50);

    write_reg(REG_HEAP_BASE, 32'h0000_1000);
    write_reg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
    settings_used++;
    repeat (200) send_random(45);

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (1100) @(posedge clk_i);

    $display("%0d requests over %0d heap settings, %0d results checked", items_sent,
             settings_used, results_seen);
    $display("ok %0d, null %0d, no fit %0d, no slot %0d, not found %0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nfpa_pkg.sv
rtl/core/nfpa_if.sv
rtl/core/nfpa_engine.sv
rtl/core/next_fit_page_allocator_unit.sv
dv/next_fit_page_allocator_unit_tb.sv
